@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock edge, off while reset is low.
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Overlapping implication, sampled on the rising clock edge, off while reset is low.
`define BBA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/bba_pkg.sv @@
// Shared types, codes and constants of the block bitmap allocator.
package bba_pkg;

    localparam int DEF_BITMAP_BLOCK_BYTES = 512;
    localparam int DEF_MAX_BITMAP_BLOCKS  = 8;

    localparam int BN_W    = 15;
    localparam int CMD_W   = 2;
    localparam int WORD_W  = 32;
    localparam int FDB_W   = 15;
    localparam int BBU_W   = 4;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    localparam logic [WORD_W-1:0] FULL_WORD = 32'hffff_ffff;

    localparam logic [FDB_W-1:0] FDB_RESET = 15'd0;
    localparam logic [BBU_W-1:0] BBU_RESET = 4'd8;

    // Register indexes, taken from paddr above the byte lanes
    localparam logic REG_FIRST_DATA_BLOCK   = 1'b0;
    localparam logic REG_BITMAP_BLOCKS_USED = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_ALLOC = 2'd2,
        CMD_FREE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd            command;
        logic [BN_W-1:0] block_number;
        logic            used_value;
    } t_req;

    typedef struct packed {
        logic            bit_value;
        logic [BN_W-1:0] allocated_block;
        t_status         status;
    } t_rsp;

    // Controller to datapath
    typedef struct packed {
        logic clr_step;
        logic load_req;
        logic mem_rd;
        logic scan_next;
        logic fin_rmw;
        logic fin_hit;
        logic fin_nospace;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_alloc;
        logic start_past;
        logic word_full;
        logic scan_last;
        logic out_free;
    } t_dp_stat;

endpackage

@@ sv/bba_stream_if.sv @@
// Valid/ready channel carrying one request or response payload.
interface bba_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/bba_apb_regs.sv @@
// APB configuration registers: first data block and bitmap blocks in use.
module bba_apb_regs
    import bba_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [FDB_W-1:0]  o_first_data_block,
    output logic [BBU_W-1:0]  o_bitmap_blocks_used
);

    logic [FDB_W-1:0] r_fdb;
    logic [BBU_W-1:0] r_bbu;
    logic             wr_en;
    logic             reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fdb <= FDB_RESET;
            r_bbu <= BBU_RESET;
        end else if (wr_en) begin
            if (reg_idx == REG_FIRST_DATA_BLOCK) begin
                r_fdb <= pwdata[FDB_W-1:0];
            end else begin
                r_bbu <= pwdata[BBU_W-1:0];
            end
        end
    end

    always_comb begin
        if (reg_idx == REG_FIRST_DATA_BLOCK) begin
            prdata = APB_DW'(r_fdb);
        end else begin
            prdata = APB_DW'(r_bbu);
        end
    end

    assign o_first_data_block   = r_fdb;
    assign o_bitmap_blocks_used = r_bbu;

endmodule

@@ sv/bba_dpath.sv @@
// Bitmap memory, address and search logic, and the response register.
module bba_dpath
    import bba_pkg::*;
#(
    parameter int BITMAP_BLOCK_BYTES = DEF_BITMAP_BLOCK_BYTES,
    parameter int MAX_BITMAP_BLOCKS  = DEF_MAX_BITMAP_BLOCKS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_cmd,
    output t_dp_stat         o_stat,
    input  t_req             i_req_data,
    input  logic [FDB_W-1:0] i_first_data_block,
    input  logic [BBU_W-1:0] i_bitmap_blocks_used,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp_data
);

    localparam int WPB         = BITMAP_BLOCK_BYTES / 4;
    localparam int BPB         = BITMAP_BLOCK_BYTES * 8;
    localparam int TOTAL_WORDS = MAX_BITMAP_BLOCKS * WPB;
    localparam int AW          = $clog2(TOTAL_WORDS);
    localparam int EW          = AW + 1;
    localparam int TOTAL_BITS  = TOTAL_WORDS * WORD_W;
    localparam int SPAN_W      = $clog2(TOTAL_BITS + 1);
    localparam int CW          = (SPAN_W > BN_W) ? SPAN_W : BN_W;
    localparam int MAXB_W      = $clog2(MAX_BITMAP_BLOCKS + 1);
    localparam int LIM_W       = (MAXB_W > BBU_W) ? MAXB_W : BBU_W;

    logic [WORD_W-1:0] r_mem [TOTAL_WORDS];
    logic [WORD_W-1:0] r_rdata;
    logic [AW-1:0]     r_addr;
    t_req              r_req;
    logic              r_out_valid;
    t_rsp              r_out;

    logic [AW-1:0]     n_addr;
    t_rsp              n_out;
    logic              n_out_valid;

    logic [LIM_W-1:0]  limit;
    logic [CW-1:0]     span;
    logic [EW-1:0]     end_word;
    logic [CW-1:0]     fdb_ext;
    logic [LIM_W-1:0]  start_idx;
    logic [AW-1:0]     start_word;
    logic [CW-1:0]     in_blk_ext;
    logic [CW-1:0]     rq_blk_ext;
    logic              in_range;
    logic [4:0]        bit_sel;
    logic [WORD_W-1:0] bit_mask;
    logic [4:0]        free_bit;
    logic [AW+4:0]     got_block;
    logic [WORD_W-1:0] hit_word;
    logic [WORD_W-1:0] rmw_word;
    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic              out_load;
    logic              out_free;

    // Active bitmap size, capped at the built size
    always_comb begin
        if (LIM_W'(i_bitmap_blocks_used) > LIM_W'(MAX_BITMAP_BLOCKS)) begin
            limit = LIM_W'(MAX_BITMAP_BLOCKS);
        end else begin
            limit = LIM_W'(i_bitmap_blocks_used);
        end
    end

    assign span     = CW'(limit) * CW'(BPB);
    assign end_word = EW'(limit) * EW'(WPB);
    assign fdb_ext  = CW'(i_first_data_block);

    // Bitmap block holding the first data block, by comparison with each block start
    always_comb begin
        start_idx = '0;
        for (int i = 1; i < MAX_BITMAP_BLOCKS; i++) begin
            if (fdb_ext >= CW'(i * BPB)) begin
                start_idx = LIM_W'(i);
            end
        end
    end

    assign start_word = AW'(start_idx * WPB);
    assign in_blk_ext = CW'(i_req_data.block_number);
    assign rq_blk_ext = CW'(r_req.block_number);
    assign in_range   = rq_blk_ext < span;
    assign bit_sel    = r_req.block_number[4:0];
    assign bit_mask   = WORD_W'(1) << bit_sel;

    // Lowest clear bit of the word just read
    always_comb begin
        free_bit = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (!r_rdata[b]) begin
                free_bit = 5'(b);
            end
        end
    end

    assign got_block = {r_addr, free_bit};
    assign hit_word  = r_rdata | (WORD_W'(1) << free_bit);

    always_comb begin
        if (r_req.command == CMD_WRITE && r_req.used_value) begin
            rmw_word = r_rdata | bit_mask;
        end else begin
            rmw_word = r_rdata & ~bit_mask;
        end
    end

    assign mem_we = i_cmd.clr_step || i_cmd.fin_hit
                 || (i_cmd.fin_rmw && in_range && r_req.command != CMD_READ);

    always_comb begin
        priority if (i_cmd.clr_step) begin
            mem_wdata = '0;
        end else if (i_cmd.fin_hit) begin
            mem_wdata = hit_word;
        end else begin
            mem_wdata = rmw_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_addr] <= mem_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    always_comb begin
        priority if (i_cmd.load_req) begin
            if (i_req_data.command == CMD_ALLOC) begin
                n_addr = start_word;
            end else begin
                n_addr = in_blk_ext[AW+4:5];
            end
        end else if (i_cmd.clr_step || i_cmd.scan_next) begin
            n_addr = r_addr + AW'(1);
        end else begin
            n_addr = r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req <= i_req_data;
        end
    end

    // Response register: a finished response waits here while the next request is taken
    assign out_load = i_cmd.fin_rmw || i_cmd.fin_hit || i_cmd.fin_nospace;
    assign out_free = !r_out_valid || i_rsp_ready;

    always_comb begin
        n_out.bit_value       = 1'b0;
        n_out.allocated_block = '0;
        n_out.status          = ST_OK;
        priority if (i_cmd.fin_nospace) begin
            n_out.status = ST_NOSPACE;
        end else if (i_cmd.fin_hit) begin
            n_out.allocated_block = BN_W'(got_block);
        end else if (!in_range) begin
            n_out.status = ST_RANGE;
        end else if (r_req.command == CMD_READ) begin
            n_out.bit_value = r_rdata[bit_sel];
        end else begin
            n_out.bit_value = 1'b0;
        end
    end

    always_comb begin
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (i_rsp_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= n_out;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_data  = r_out;

    assign o_stat.clr_last   = r_addr == AW'(TOTAL_WORDS - 1);
    assign o_stat.is_alloc   = r_req.command == CMD_ALLOC;
    assign o_stat.start_past = fdb_ext >= span;
    assign o_stat.word_full  = r_rdata == FULL_WORD;
    assign o_stat.scan_last  = (EW'(r_addr) + EW'(1)) == end_word;
    assign o_stat.out_free   = out_free;

endmodule

@@ sv/bba_ctrl.sv @@
// Controller: clearing pass, request sequencing and the allocation scan.
module bba_ctrl
    import bba_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state        = S_READ;
                end
            end
            S_READ: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                // before finishing, hold here while the response register is still occupied
                if (!i_stat.is_alloc) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin_rmw = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.start_past) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin_nospace = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else if (!i_stat.word_full) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin_hit = 1'b1;
                        n_state       = S_IDLE;
                    end
                end else if (i_stat.scan_last) begin
                    if (i_stat.out_free) begin
                        o_cmd.fin_nospace = 1'b1;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state         = S_READ;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    assign o_req_ready = r_state == S_IDLE;

endmodule

@@ sv/block_bitmap_allocator_top.sv @@
// Block bitmap allocator: one used-bit per storage block, first-fit allocation.
//
// Requests arrive on i_req (command, block_number, used_value) and are taken when
// valid and ready are both high; one response per request leaves on o_rsp
// (bit_value, allocated_block, status). Two registers set up the allocator over
// APB: first_data_block at byte 0 and bitmap_blocks_used at byte 4. Write them
// only while no request is in flight.
// Read, write and free pass through the READ and CHECK states before the next
// request is accepted; the response is registered as CHECK finishes. Allocate
// reads one bitmap word per READ and CHECK pass (single-port memory read, then
// test) from the start of the bitmap block that holds first_data_block, over up
// to MAX_BITMAP_BLOCKS*BITMAP_BLOCK_BYTES/4 words.
// After reset the bitmap memory is swept to zero, one word a cycle (1024 words
// at the default size); i_req.ready stays low until the sweep ends, while APB
// writes are taken as usual. A response that the receiver stalls waits in the
// output register and the next request is still accepted; its result is held
// back until the earlier response has been taken.
module block_bitmap_allocator_top
    import bba_pkg::*;
#(
    parameter int BITMAP_BLOCK_BYTES = DEF_BITMAP_BLOCK_BYTES,
    parameter int MAX_BITMAP_BLOCKS  = DEF_MAX_BITMAP_BLOCKS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    bba_stream_if.sink        i_req,
    bba_stream_if.source      o_rsp
);

    logic [FDB_W-1:0] first_data_block;
    logic [BBU_W-1:0] bitmap_blocks_used;
    t_dp_cmd          dp_cmd;
    t_dp_stat         dp_stat;
    t_req             req_data;
    t_rsp             rsp_data;
    logic             req_ready;
    logic             rsp_valid;

    assign req_data      = i_req.payload;
    assign i_req.ready   = req_ready;
    assign o_rsp.valid   = rsp_valid;
    assign o_rsp.payload = rsp_data;

    bba_apb_regs u_regs (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .o_first_data_block   (first_data_block),
        .o_bitmap_blocks_used (bitmap_blocks_used)
    );

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bba_dpath #(
        .BITMAP_BLOCK_BYTES (BITMAP_BLOCK_BYTES),
        .MAX_BITMAP_BLOCKS  (MAX_BITMAP_BLOCKS)
    ) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_stat               (dp_stat),
        .i_req_data           (req_data),
        .i_first_data_block   (first_data_block),
        .i_bitmap_blocks_used (bitmap_blocks_used),
        .o_rsp_valid          (rsp_valid),
        .i_rsp_ready          (o_rsp.ready),
        .o_rsp_data           (rsp_data)
    );

endmodule

@@ sv/bba_checker.sv @@
// Port-level checks of the allocator, bound to the top level.
`include "assert_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_rsp_valid,
    input logic            i_rsp_ready,
    input logic            i_rsp_bit_value,
    input logic [BN_W-1:0] i_rsp_allocated_block,
    input t_status         i_rsp_status
);

    logic            rsp_stall;
    logic            req_take;
    logic            rsp_err;
    logic            err_clean;
    logic [BN_W+2:0] rsp_word;

    assign rsp_stall = i_rsp_valid && !i_rsp_ready;
    assign req_take  = i_req_valid && i_req_ready;
    assign rsp_err   = i_rsp_valid && (i_rsp_status != ST_OK);
    assign err_clean = !i_rsp_bit_value && (i_rsp_allocated_block == '0);
    assign rsp_word  = {i_rsp_bit_value, i_rsp_allocated_block, i_rsp_status};

    `BBA_ASSERT(a_rsp_hold, i_clk, i_rst_n, rsp_stall |=> i_rsp_valid, "stalled response lost")
    `BBA_ASSERT(a_rsp_stable, i_clk, i_rst_n, rsp_stall |=> $stable(rsp_word), "response changed")
    `BBA_ASSERT_IMPL(a_err_fields, i_clk, i_rst_n, rsp_err, err_clean, "error with data")
    `BBA_ASSERT(a_one_at_a_time, i_clk, i_rst_n, req_take |=> !i_req_ready, "request overlap")
    `BBA_ASSERT_IMPL(a_clear_pass, i_clk, i_rst_n, $past(!i_rst_n), !i_req_ready, "early ready")

endmodule

bind block_bitmap_allocator_top bba_checker u_bba_checker (
    .i_clk                 (i_clk),
    .i_rst_n               (i_rst_n),
    .i_req_valid           (i_req.valid),
    .i_req_ready           (i_req.ready),
    .i_rsp_valid           (o_rsp.valid),
    .i_rsp_ready           (o_rsp.ready),
    .i_rsp_bit_value       (o_rsp.payload.bit_value),
    .i_rsp_allocated_block (o_rsp.payload.allocated_block),
    .i_rsp_status          (o_rsp.payload.status)
);
